[sv/ptc_pkg.sv]
// shared types and constants for the pressure and temperature compensation block
package ptc_pkg;

    localparam int DivW = 64;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 48;

    localparam logic [CfgIdxW-1:0] REG_TEMP       = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_LOW  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_MID  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH = 2'd3;

    localparam logic signed [26:0] TEMP_OFFSET = 27'sd128000;
    localparam logic [20:0] PRESS_FULL = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE = 12'd3125;
    localparam logic [63:0] X_BIAS = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [19:0] adc_temp;
        logic [19:0] adc_press;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pressure_q24_8;
        logic signed [31:0] fine_temp;
        logic div_zero;
    } out_item_t;

    typedef struct packed {
        logic [31:0] fine_temp;
        logic div_zero;
    } tag_t;

endpackage

[sv/ptc_div.sv]
// pipelined signed 64-bit divider, one quotient bit per stage
module ptc_div #(
    parameter int W = ptc_pkg::DivW
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [W-1:0]   num,
    input  logic [W-1:0]   den,
    input  ptc_pkg::tag_t  in_tag,
    output logic           out_valid,
    output logic [W-1:0]   quo,
    output ptc_pkg::tag_t  out_tag
);

    logic          vld_reg [0:W];
    logic [W-1:0]  rem_reg [0:W];
    logic [W-1:0]  qt_reg  [0:W];
    logic [W-1:0]  dsr_reg [0:W];
    logic          neg_reg [0:W];
    ptc_pkg::tag_t tag_reg [0:W];

    logic          ovld_reg;
    logic [W-1:0]  quo_reg;
    ptc_pkg::tag_t otag_reg;

    logic [W:0]    trial [1:W];
    logic [W:0]    diff  [1:W];

    always_comb
    begin
        for (int k = 1; k <= W; k++)
        begin
            trial[k] = {rem_reg[k-1], qt_reg[k-1][W-1]};
            diff[k]  = trial[k] - {1'b0, dsr_reg[k-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            ovld_reg <= 1'b0;
        end
        else
        begin
            // magnitudes and result sign
            vld_reg[0] <= in_valid;
            rem_reg[0] <= '0;
            qt_reg[0]  <= num[W-1] ? (~num + 1'b1) : num;
            dsr_reg[0] <= den[W-1] ? (~den + 1'b1) : den;
            neg_reg[0] <= num[W-1] ^ den[W-1];
            tag_reg[0] <= in_tag;

            for (int k = 1; k <= W; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
                rem_reg[k] <= diff[k][W] ? trial[k][W-1:0] : diff[k][W-1:0];
                qt_reg[k]  <= {qt_reg[k-1][W-2:0], ~diff[k][W]};
                dsr_reg[k] <= dsr_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end

            ovld_reg <= vld_reg[W];
            quo_reg  <= neg_reg[W] ? (~qt_reg[W] + 1'b1) : qt_reg[W];
            otag_reg <= tag_reg[W];
        end
    end

    assign out_valid = ovld_reg;
    assign quo       = quo_reg;
    assign out_tag   = otag_reg;

endmodule

[sv/pressure_temp_compensation.sv]
// top level of the pressure and temperature compensation pipeline
//
// usage:
//   write the four calibration registers through cfg_valid/cfg_ready,
//   cfg_index and cfg_data while no item is in flight; cfg_ready is always high
//   an item (sample) is taken at each edge where start is high and busy is low;
//   busy stays low, so one item can enter every cycle
//   each item gives one result on result, marked by done for one cycle,
//   once the item has passed the multiply stages and the divider
//   throughput is one item per cycle; the divider is a 64-stage
//   quotient pipeline with multiply stages before and after it
//   results leave in the order the items came in
//   reset clears the calibration registers to zero and drops all items in flight
//   the receiver cannot stall, so there is no backpressure path
//   div_zero marks an item whose divisor term was zero; its pressure reads zero
//
module pressure_temp_compensation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ptc_pkg::in_item_t                 sample,
    output logic                              done,
    output ptc_pkg::out_item_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptc_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [ptc_pkg::CfgDataW-1:0]      cfg_data
);

    logic [ptc_pkg::CfgDataW-1:0] tc_reg, pl_reg, pm_reg, ph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0;
            pl_reg <= '0;
            pm_reg <= '0;
            ph_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ptc_pkg::REG_TEMP:       tc_reg <= cfg_data;
                ptc_pkg::REG_PRESS_LOW:  pl_reg <= cfg_data;
                ptc_pkg::REG_PRESS_MID:  pm_reg <= cfg_data;
                ptc_pkg::REG_PRESS_HIGH: ph_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = tc_reg[15:0];
    assign t2 = $signed(tc_reg[31:16]);
    assign t3 = $signed(tc_reg[47:32]);
    assign p1 = pl_reg[15:0];
    assign p2 = $signed(pl_reg[31:16]);
    assign p3 = $signed(pl_reg[47:32]);
    assign p4 = $signed(pm_reg[15:0]);
    assign p5 = $signed(pm_reg[31:16]);
    assign p6 = $signed(pm_reg[47:32]);
    assign p7 = $signed(ph_reg[15:0]);
    assign p8 = $signed(ph_reg[31:16]);
    assign p9 = $signed(ph_reg[47:32]);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic [19:0] ap1_reg, ap2_reg, ap3_reg, ap4_reg, ap5_reg, ap6_reg;

    // stage 1: temperature products
    logic signed [17:0] diff1;
    logic signed [16:0] dt;
    logic signed [33:0] pa_next, dd_next;
    logic signed [33:0] pa_reg, dd_reg;

    assign diff1   = $signed({1'b0, sample.adc_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign dt      = $signed({1'b0, sample.adc_temp[19:4]}) - $signed({1'b0, t1});
    assign pa_next = diff1 * t2;
    assign dd_next = dt * dt;

    // stage 2
    logic signed [21:0] dds;
    logic signed [37:0] ddp_next, ddp_reg;
    logic signed [22:0] a_reg;

    assign dds      = $signed({1'b0, dd_reg[32:12]});
    assign ddp_next = dds * t3;

    // stage 3: fine temperature
    logic signed [23:0] bt;
    logic signed [31:0] tf_next, tf3_reg;

    assign bt      = ddp_reg[37:14];
    assign tf_next = {{9{a_reg[22]}}, a_reg} + {{8{bt[23]}}, bt};

    // stage 4: offset temperature products
    logic signed [26:0] xo;
    logic signed [53:0] xx_reg;
    logic signed [42:0] xp5_reg, xp2_reg;
    logic [31:0]        tf4_reg;

    assign xo = $signed(tf3_reg[26:0]) - ptc_pkg::TEMP_OFFSET;

    // stage 5
    logic signed [69:0] y1p, x2p;
    logic [63:0]        y1_reg, x2a_reg, ys_reg;
    logic signed [42:0] xp2b_reg;
    logic [31:0]        tf5_reg;
    logic [63:0]        ys_next;

    assign y1p     = xx_reg * p6;
    assign x2p     = xx_reg * p3;
    assign ys_next = ({{21{xp5_reg[42]}}, xp5_reg} << 17) + ({{48{p4[15]}}, p4} << 35);

    // stage 6
    logic signed [63:0] x2;
    logic [63:0]        s_reg, y_reg;
    logic [31:0]        tf6_reg;

    assign x2 = ($signed(x2a_reg) >>> 8) + $signed({{21{xp2b_reg[42]}}, xp2b_reg} << 12);

    // stage 7
    logic [20:0] pp;
    logic [47:0] lo_reg;
    logic [47:0] hi_full;
    logic [31:0] hi_reg;
    logic [63:0] nm_reg;
    logic [31:0] tf7_reg;

    assign pp      = ptc_pkg::PRESS_FULL - {1'b0, ap6_reg};
    assign hi_full = s_reg[63:32] * p1;

    // stage 8
    logic [63:0] x3f;
    logic [63:0] x3_reg;
    logic [43:0] nlo_reg;
    logic [43:0] nhi_full;
    logic [31:0] nhi_reg;
    logic [31:0] tf8_reg;

    assign x3f      = {16'b0, lo_reg} + {hi_reg, 32'b0};
    assign nhi_full = nm_reg[63:32] * ptc_pkg::PRESS_SCALE;

    // stage 9: division operands
    logic [63:0]   num_reg, den_reg;
    ptc_pkg::tag_t tag9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;

            pa_reg  <= pa_next;
            dd_reg  <= dd_next;
            ap1_reg <= sample.adc_press;

            ddp_reg <= ddp_next;
            a_reg   <= pa_reg[33:11];
            ap2_reg <= ap1_reg;

            tf3_reg <= tf_next;
            ap3_reg <= ap2_reg;

            xx_reg  <= xo * xo;
            xp5_reg <= xo * p5;
            xp2_reg <= xo * p2;
            tf4_reg <= tf3_reg;
            ap4_reg <= ap3_reg;

            y1_reg   <= y1p[63:0];
            x2a_reg  <= x2p[63:0];
            ys_reg   <= ys_next;
            xp2b_reg <= xp2_reg;
            tf5_reg  <= tf4_reg;
            ap5_reg  <= ap4_reg;

            s_reg   <= ptc_pkg::X_BIAS + $unsigned(x2);
            y_reg   <= y1_reg + ys_reg;
            tf6_reg <= tf5_reg;
            ap6_reg <= ap5_reg;

            lo_reg  <= s_reg[31:0] * p1;
            hi_reg  <= hi_full[31:0];
            nm_reg  <= ({43'b0, pp} << 31) - y_reg;
            tf7_reg <= tf6_reg;

            x3_reg  <= {{33{x3f[63]}}, x3f[63:33]};
            nlo_reg <= nm_reg[31:0] * ptc_pkg::PRESS_SCALE;
            nhi_reg <= nhi_full[31:0];
            tf8_reg <= tf7_reg;

            num_reg            <= {20'b0, nlo_reg} + {nhi_reg, 32'b0};
            den_reg            <= x3_reg;
            tag9_reg.fine_temp <= tf8_reg;
            tag9_reg.div_zero  <= (x3_reg == '0);
        end
    end

    logic          dv;
    logic [63:0]   q;
    ptc_pkg::tag_t dtag;

    ptc_div #(
        .W(ptc_pkg::DivW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v9_reg),
        .num       (num_reg),
        .den       (den_reg),
        .in_tag    (tag9_reg),
        .out_valid (dv),
        .quo       (q),
        .out_tag   (dtag)
    );

    // post stage 1
    logic signed [50:0] s13;
    logic signed [66:0] m1p;
    logic signed [48:0] plp;
    logic signed [47:0] php;
    logic               w1_reg, w2_reg, w3_reg, done_reg;
    logic [63:0]        m1_reg, q1_reg, q2_reg, q3_reg;
    logic signed [50:0] s13_reg;
    logic signed [48:0] pl8_reg;
    logic [31:0]        ph8_reg;
    ptc_pkg::tag_t      tg1_reg, tg2_reg, tg3_reg;

    assign s13 = q[63:13];
    assign m1p = p9 * s13;
    assign plp = p8 * $signed({1'b0, q[31:0]});
    assign php = p8 * $signed(q[63:32]);

    // post stage 2
    logic [63:0] se;
    logic [63:0] bp, cp;
    logic [63:0] ma_reg;
    logic [31:0] mb_reg, mc_reg;
    logic signed [63:0] yv, yb_reg, yb3_reg;

    assign se = {{13{s13_reg[50]}}, s13_reg};
    assign bp = m1_reg[31:0] * se[63:32];
    assign cp = m1_reg[63:32] * se[31:0];
    assign yv = $signed({{15{pl8_reg[48]}}, pl8_reg}) + $signed({ph8_reg, 32'b0});

    // post stage 3
    logic [31:0]        bc;
    logic [63:0]        xv;
    logic signed [63:0] xb_reg;

    assign bc = mb_reg + mc_reg;
    assign xv = ma_reg + {bc, 32'b0};

    // output stage
    logic signed [63:0] psum, pout;
    ptc_pkg::out_item_t result_reg;

    assign psum = $signed(q3_reg) + xb_reg + yb3_reg;
    assign pout = (psum >>> 8) + ($signed({{48{p7[15]}}, p7}) <<< 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg   <= 1'b0;
            w2_reg   <= 1'b0;
            w3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            w1_reg   <= dv;
            w2_reg   <= w1_reg;
            w3_reg   <= w2_reg;
            done_reg <= w3_reg;

            m1_reg  <= m1p[63:0];
            s13_reg <= s13;
            pl8_reg <= plp;
            ph8_reg <= php[31:0];
            q1_reg  <= q;
            tg1_reg <= dtag;

            ma_reg  <= m1_reg[31:0] * se[31:0];
            mb_reg  <= bp[31:0];
            mc_reg  <= cp[31:0];
            yb_reg  <= yv >>> 19;
            q2_reg  <= q1_reg;
            tg2_reg <= tg1_reg;

            xb_reg  <= $signed(xv) >>> 25;
            yb3_reg <= yb_reg;
            q3_reg  <= q2_reg;
            tg3_reg <= tg2_reg;

            result_reg.pressure_q24_8 <= tg3_reg.div_zero ? 32'd0 : pout[31:0];
            result_reg.fine_temp      <= $signed(tg3_reg.fine_temp);
            result_reg.div_zero       <= tg3_reg.div_zero;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
